[rtl/bm3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_pkg: shared types and constants of the 3x3 morphology filter
// Field widths, command and mode codes, register indexes and the row store
// word layout.
// ----------------------------------------------------------------------------
package bm3_pkg;

	localparam int PIX_W      = 8;
	localparam int IMG_W_W    = 11;
	localparam int IMG_H_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
	localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

	localparam logic [IMG_W_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [IMG_H_W-1:0] HEIGHT_RESET = 16'd480;

	// item kinds on the input tuser
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// filter modes
	localparam logic MODE_ERODE  = 1'b0;
	localparam logic MODE_DILATE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 2'd2;

	// one row store word: the two rows above the current input row
	typedef struct packed {
		logic [PIX_W-1:0] upper;
		logic [PIX_W-1:0] lower;
	} row_pair_t;

endpackage

[rtl/bm3_row_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_row_store: line buffer memory for two previous rows
// One write and one read port, registered read data, write-to-read
// forwarding for a read that hits the address being written the same cycle.
// ----------------------------------------------------------------------------
module bm3_row_store #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  bm3_pkg::row_pair_t       wr_data,
	output bm3_pkg::row_pair_t       rd_data
);

	bm3_pkg::row_pair_t mem [DEPTH];
	bm3_pkg::row_pair_t rd_mem_q;
	bm3_pkg::row_pair_t fwd_data_q;
	logic               fwd_hit_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	// memory returns old data on a same-address collision: take the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else if (rd_en) begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = fwd_hit_q ? fwd_data_q : rd_mem_q;

endmodule

[rtl/binary_morphology_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3: streaming 3x3 erosion / dilation
// Raster-order 8-bit pixel stream in, filtered pixel stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item per handshake: tuser is the kind (pixel or
//   drain), tdata the pixel. m_axis returns filtered pixels in raster order
//   with tlast on the bottom-right pixel of a frame. The cfg channel writes
//   img_width, img_height and filter_mode; write it only while idle.
//   Results trail the input by img_width+1 pixels; at the end of a frame
//   send drain items, each of which pushes out one pending result.
//   Throughput is one item per clock while m_axis takes its results: the row
//   store does one read and one write-back per cycle, with forwarding when
//   consecutive items hit the same column. An item's result enters the
//   output register when the read stage fires: the row store read and the
//   read stage load at the accepting edge, the window update and compare
//   finish as the read stage fires, provided the output register is free by then.
//   Reset clears the position counters, the window and the registers to
//   640 x 480 erosion; the row store is not cleared and needs no sweep.
//   When m_axis stalls, the output register holds its item, one more item
//   waits in the read stage, and s_axis_tready drops only if that item
//   also has a result to deliver.
// ----------------------------------------------------------------------------
module binary_morphology_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bm3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bm3_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [bm3_pkg::PIX_W-1:0]        s_axis_tdata,  // [7:0] pixel_in
	input  logic                             s_axis_tuser,  // [0] cmd
	// output stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [bm3_pkg::PIX_W-1:0]        m_axis_tdata,  // [7:0] pixel_out
	output logic                             m_axis_tlast   // last_of_frame
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int W_W    = $clog2(MAX_WIDTH + 1);
	localparam int PEND_W = $clog2(MAX_WIDTH + 3);
	localparam int ROW_W  = bm3_pkg::IMG_H_W;

	// ---------------- configuration registers ----------------
	logic [bm3_pkg::IMG_W_W-1:0] img_width_q;
	logic [bm3_pkg::IMG_H_W-1:0] img_height_q;
	logic                        filter_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q   <= bm3_pkg::WIDTH_RESET;
			img_height_q  <= bm3_pkg::HEIGHT_RESET;
			filter_mode_q <= bm3_pkg::MODE_ERODE;
		end else if (cfg_valid) begin
			case (cfg_index)
				bm3_pkg::REG_IMG_WIDTH:   img_width_q   <= cfg_data[bm3_pkg::IMG_W_W-1:0];
				bm3_pkg::REG_IMG_HEIGHT:  img_height_q  <= cfg_data[bm3_pkg::IMG_H_W-1:0];
				bm3_pkg::REG_FILTER_MODE: filter_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero acts as one, width clamps to the line buffer
	logic [W_W-1:0]   eff_w;
	logic [ROW_W-1:0] eff_h;

	always_comb begin
		if (img_width_q == '0) begin
			eff_w = W_W'(1);
		end else if (32'(img_width_q) > MAX_WIDTH) begin
			eff_w = W_W'(MAX_WIDTH);
		end else begin
			eff_w = W_W'(img_width_q);
		end
		eff_h = (img_height_q == '0) ? ROW_W'(1) : img_height_q;
	end

	// ---------------- position tracking at accept ----------------
	logic [ROW_W-1:0]  in_row_q, in_row_d, out_row_q, out_row_d;
	logic [COL_W-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
	logic [PEND_W-1:0] pend_q, pend_d;

	logic [W_W-1:0]    in_col_inc, out_col_inc;
	logic [ROW_W:0]    in_row_inc, out_row_inc;
	logic [ROW_W-1:0]  in_row_adv, out_row_adv;
	logic [COL_W-1:0]  in_col_adv, out_col_adv;
	logic              take_shift, take_emit, interior_c, last_c;

	logic s_accept;
	logic fire;
	logic out_free;

	assign s_accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_col_inc  = W_W'(in_col_q) + 1'b1;
		in_row_inc  = {1'b0, in_row_q} + 1'b1;
		out_col_inc = W_W'(out_col_q) + 1'b1;
		out_row_inc = {1'b0, out_row_q} + 1'b1;

		// wrap at the frame size; a counter past a shrunken size wraps too
		if (in_col_inc >= eff_w) begin
			in_col_adv = '0;
			in_row_adv = (in_row_inc >= {1'b0, eff_h}) ? '0 : in_row_inc[ROW_W-1:0];
		end else begin
			in_col_adv = in_col_inc[COL_W-1:0];
			in_row_adv = in_row_q;
		end
		if (out_col_inc >= eff_w) begin
			out_col_adv = '0;
			out_row_adv = (out_row_inc >= {1'b0, eff_h}) ? '0 : out_row_inc[ROW_W-1:0];
		end else begin
			out_col_adv = out_col_inc[COL_W-1:0];
			out_row_adv = out_row_q;
		end

		interior_c = (out_row_q != '0) && (out_row_inc < {1'b0, eff_h}) &&
		             (out_col_q != '0) && (out_col_inc < eff_w);
		last_c     = (out_row_inc >= {1'b0, eff_h}) && (out_col_inc >= eff_w);

		in_row_d   = in_row_q;
		in_col_d   = in_col_q;
		out_row_d  = out_row_q;
		out_col_d  = out_col_q;
		pend_d     = pend_q;
		take_shift = 1'b0;
		take_emit  = 1'b0;

		case (s_axis_tuser)
			bm3_pkg::CMD_PIXEL: begin
				take_shift = 1'b1;
				in_row_d   = in_row_adv;
				in_col_d   = in_col_adv;
				// emit once more than width pixels are already pending
				if (pend_q > PEND_W'(eff_w)) begin
					take_emit = 1'b1;
					out_row_d = out_row_adv;
					out_col_d = out_col_adv;
				end else begin
					pend_d = pend_q + 1'b1;
				end
			end
			bm3_pkg::CMD_DRAIN: begin
				if (pend_q != '0) begin
					take_shift = 1'b1;
					take_emit  = 1'b1;
					pend_d     = pend_q - 1'b1;
					if (pend_q == PEND_W'(1)) begin
						// pipeline empty: next pixel starts a fresh frame
						in_row_d  = '0;
						in_col_d  = '0;
						out_row_d = '0;
						out_col_d = '0;
					end else begin
						in_row_d  = in_row_adv;
						in_col_d  = in_col_adv;
						out_row_d = out_row_adv;
						out_col_d = out_col_adv;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			pend_q    <= '0;
		end else if (s_accept) begin
			in_row_q  <= in_row_d;
			in_col_q  <= in_col_d;
			out_row_q <= out_row_d;
			out_col_q <= out_col_d;
			pend_q    <= pend_d;
		end
	end

	// ---------------- read stage ----------------
	logic                     valid_s1;
	logic [bm3_pkg::PIX_W-1:0] px_s1;
	logic [COL_W-1:0]         idx_s1;
	logic                     emit_s1;
	logic                     interior_s1;
	logic                     last_s1;

	// advance the read stage when its result (if any) has a free output slot
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign fire          = valid_s1 && (!emit_s1 || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= take_shift;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			px_s1       <= (s_axis_tuser == bm3_pkg::CMD_PIXEL) ? s_axis_tdata
			                                                     : bm3_pkg::PIX_ZERO;
			idx_s1      <= in_col_q;
			emit_s1     <= take_emit;
			interior_s1 <= interior_c;
			last_s1     <= last_c;
		end
	end

	// ---------------- row store: read at accept, write back at fire ----------------
	bm3_pkg::row_pair_t rows_rd;
	bm3_pkg::row_pair_t rows_wr;

	assign rows_wr.upper = rows_rd.lower;
	assign rows_wr.lower = px_s1;

	bm3_row_store #(
		.DEPTH (MAX_WIDTH)
	) u_row_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.rd_addr (in_col_q),
		.wr_en   (fire),
		.wr_addr (idx_s1),
		.wr_data (rows_wr),
		.rd_data (rows_rd)
	);

	// ---------------- window and filter ----------------
	logic [bm3_pkg::PIX_W-1:0] win_q    [3][3];
	logic [bm3_pkg::PIX_W-1:0] win_next [3][3];
	logic [bm3_pkg::PIX_W-1:0] col_new  [3];
	logic [bm3_pkg::PIX_W-1:0] key;
	logic [bm3_pkg::PIX_W-1:0] result;
	logic                      hit;

	always_comb begin
		col_new[0] = rows_rd.upper;
		col_new[1] = rows_rd.lower;
		col_new[2] = px_s1;
		for (int k = 0; k < 3; k++) begin
			win_next[k][0] = win_q[k][1];
			win_next[k][1] = win_q[k][2];
			win_next[k][2] = col_new[k];
		end

		key = (filter_mode_q == bm3_pkg::MODE_DILATE) ? bm3_pkg::PIX_FULL : bm3_pkg::PIX_ZERO;
		hit = 1'b0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				hit = hit | (win_next[r][c] == key);
			end
		end

		// border pixels pass; interior is all-or-nothing on the key
		if (!interior_s1) begin
			result = win_next[1][1];
		end else if (filter_mode_q == bm3_pkg::MODE_DILATE) begin
			result = hit ? bm3_pkg::PIX_FULL : bm3_pkg::PIX_ZERO;
		end else begin
			result = hit ? bm3_pkg::PIX_ZERO : bm3_pkg::PIX_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= bm3_pkg::PIX_ZERO;
				end
			end
		end else if (fire) begin
			win_q <= win_next;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (fire && emit_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit_s1) begin
			m_axis_tdata <= result;
			m_axis_tlast <= last_s1;
		end
	end

	// ---------------- checks ----------------
	// pending count never runs past the widest row plus one pixel
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pend_q) <= MAX_WIDTH + 1)
		else $error("pending count exceeds row plus one");

	// a held read-stage item keeps its column
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(idx_s1) && $stable(emit_s1))
		else $error("read stage item changed while stalled");

	// input stalls only behind a result that cannot leave
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && emit_s1 && m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without a blocked result");

	// draining the last pending pixel rewinds all positions
	a_drain_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_axis_tuser == bm3_pkg::CMD_DRAIN) && (pend_q == PEND_W'(1))
		|=> (pend_q == '0) && (in_col_q == '0) && (in_row_q == '0) &&
		    (out_col_q == '0) && (out_row_q == '0))
		else $error("positions not rewound after final drain");

endmodule

[verif/bm3_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm3_checker: scoreboard for the 3x3 morphology filter
// Watches the register channel and both streams, keeps its own model of the
// row stores, the window and the position counters, predicts each filtered
// pixel and compares every output item against the oldest prediction.
// ----------------------------------------------------------------------------
module bm3_checker #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [bm3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bm3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [bm3_pkg::PIX_W-1:0]      s_axis_tdata,
	input  logic                           s_axis_tuser,
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [bm3_pkg::PIX_W-1:0]      m_axis_tdata,
	input  logic                           m_axis_tlast,
	output int                             fail_count,
	output int                             results_due,
	output int                             results_seen,
	output int                             frames_seen
);
	import bm3_pkg::*;

	typedef struct packed {
		logic             last;
		logic [PIX_W-1:0] pix;
	} out_pixel_t;

	out_pixel_t expected_pixels[$];

	logic [IMG_W_W-1:0] width_reg;
	logic [IMG_H_W-1:0] height_reg;
	logic               mode_reg;

	logic [PIX_W-1:0] row_upper [MAX_WIDTH];
	logic [PIX_W-1:0] row_lower [MAX_WIDTH];
	logic [PIX_W-1:0] window [3][3];
	int unsigned      in_row, in_col, out_row, out_col, backlog;

	task automatic report_mismatch(input string msg);
		if (fail_count < 30)
			$display("%0t ns mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic int unsigned active_width();
		if (width_reg == '0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		return (height_reg == '0) ? 1 : height_reg;
	endfunction

	// raster advance; counters past a shrunken size wrap on their next step
	task automatic step_position(inout int unsigned row, inout int unsigned col,
			input int unsigned w, input int unsigned h);
		if (col + 1 >= w) begin
			col = 0;
			row = (row + 1 >= h) ? 0 : row + 1;
		end else begin
			col = col + 1;
		end
	endtask

	task automatic shift_column(input logic [PIX_W-1:0] px);
		int unsigned      idx;
		int               k;
		logic [PIX_W-1:0] fresh [3];
		idx = (in_col < MAX_WIDTH) ? in_col : MAX_WIDTH - 1;
		fresh[0] = row_upper[idx];
		fresh[1] = row_lower[idx];
		fresh[2] = px;
		row_upper[idx] = row_lower[idx];
		row_lower[idx] = px;
		for (k = 0; k < 3; k++) begin
			window[k][0] = window[k][1];
			window[k][1] = window[k][2];
			window[k][2] = fresh[k];
		end
	endtask

	task automatic emit_pixel(input int unsigned w, input int unsigned h);
		out_pixel_t       res;
		logic             hit;
		logic [PIX_W-1:0] key;
		int               r, c;
		res.pix = window[1][1];
		if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
			key = (mode_reg == MODE_DILATE) ? PIX_FULL : PIX_ZERO;
			hit = 1'b0;
			for (r = 0; r < 3; r++)
				for (c = 0; c < 3; c++)
					if (window[r][c] == key) hit = 1'b1;
			if (mode_reg == MODE_DILATE) res.pix = hit ? PIX_FULL : PIX_ZERO;
			else res.pix = hit ? PIX_ZERO : PIX_FULL;
		end
		res.last = (out_row + 1 >= h) && (out_col + 1 >= w);
		expected_pixels.push_back(res);
		step_position(out_row, out_col, w, h);
		backlog--;
	endtask

	task automatic predict_item(input logic cmd, input logic [PIX_W-1:0] px);
		int unsigned w, h;
		w = active_width();
		h = active_height();
		if (cmd == CMD_PIXEL) begin
			shift_column(px);
			step_position(in_row, in_col, w, h);
			backlog++;
			if (backlog > w + 1) emit_pixel(w, h);
		end else if (backlog != 0) begin
			// a drain pushes a zero bubble and releases one pending pixel
			shift_column(PIX_ZERO);
			step_position(in_row, in_col, w, h);
			emit_pixel(w, h);
			if (backlog == 0) begin
				in_row  = 0;
				in_col  = 0;
				out_row = 0;
				out_col = 0;
			end
		end
	endtask

	task automatic check_result(input logic [PIX_W-1:0] pix, input logic last);
		out_pixel_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch($sformatf("output item with none pending: pixel %0d last %0b",
				pix, last));
		end else begin
			want = expected_pixels.pop_front();
			if (pix !== want.pix)
				report_mismatch($sformatf("result %0d: pixel %0d, expected %0d",
					results_seen, pix, want.pix));
			if (last !== want.last)
				report_mismatch($sformatf("result %0d: last %0b, expected %0b",
					results_seen, last, want.last));
		end
		if (last === 1'b1) frames_seen++;
		results_seen++;
	endtask

	task automatic reset_model();
		int i;
		for (i = 0; i < MAX_WIDTH; i++) begin
			row_upper[i] = PIX_ZERO;
			row_lower[i] = PIX_ZERO;
		end
		for (i = 0; i < 9; i++) window[i / 3][i % 3] = PIX_ZERO;
		width_reg  = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		mode_reg   = MODE_ERODE;
		in_row     = 0;
		in_col     = 0;
		out_row    = 0;
		out_col    = 0;
		backlog    = 0;
		expected_pixels.delete();
		fail_count   = 0;
		results_due  = 0;
		results_seen = 0;
		frames_seen  = 0;
	endtask

	// compare first: a result can never belong to an item accepted in the same cycle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_model();
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata, m_axis_tlast);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IMG_WIDTH:   width_reg  = cfg_data[IMG_W_W-1:0];
					REG_IMG_HEIGHT:  height_reg = cfg_data[IMG_H_W-1:0];
					REG_FILTER_MODE: mode_reg   = cfg_data[0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_item(s_axis_tuser, s_axis_tdata);
			results_due = expected_pixels.size();
		end
	end

endmodule

[verif/binary_morphology_3x3_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_3x3_tb: regression bench for the 3x3 morphology filter
// Drives directed frames, corner sizes and mid-frame reconfiguration, then
// random frames and noisy streams under varying back-pressure, and closes
// with one run on the widest row; the checker beside the block predicts and
// compares every output pixel.
// ----------------------------------------------------------------------------
module binary_morphology_3x3_tb;
	import bm3_pkg::*;

	localparam int MAX_WIDTH     = 1024;
	localparam int PERIOD        = 10;
	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 8;     // read stage + window stage, with margin
	localparam int RANDOM_ITEMS  = 520;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_IMG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = PIX_ZERO;  // [7:0] pixel_in
	logic                  s_axis_tuser  = CMD_PIXEL; // [0] cmd
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;              // [7:0] pixel_out
	logic                  m_axis_tlast;              // last_of_frame

	int fail_count, results_due, results_seen, frames_seen;

	// percentages of cycles in which each side holds off
	int send_idle_pct = 7;
	int recv_idle_pct = 58;

	// what the stimulus side knows of the current geometry
	int unsigned active_w    = 640;
	int unsigned active_h    = 480;
	int unsigned drain_depth = 641;
	// pixels since the pipeline was last emptied: the backlog never exceeds it
	int unsigned since_flush = 0;

	int pixels_sent, drains_sent, reg_writes, random_items, cycles;

	always #(PERIOD / 2) clk = ~clk;

	binary_morphology_3x3 #(.MAX_WIDTH(MAX_WIDTH)) dut (.*);

	bm3_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.fail_count    (fail_count),
		.results_due   (results_due),
		.results_seen  (results_seen),
		.frames_seen   (frames_seen)
	);

	// Receiver back-pressure: redraw tready every falling edge.
	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

	// Watchdog: a missing result or a hung handshake ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, results_due);
			$display("Regression FAIL");
			$finish;
		end
	end

	// Write one register; leave cfg_valid high so back-to-back writes need
	// no second assignment in the same step. configure() drops it at the end.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		reg_writes++;
	endtask

	// Program all three registers. Mode goes out with junk in the upper bits,
	// which the block must mask off.
	task automatic configure(input logic [CFG_DATA_W-1:0] width_data,
			input logic [CFG_DATA_W-1:0] height_data, input logic mode);
		int unsigned w_eff;
		w_eff = width_data[IMG_W_W-1:0];
		if (w_eff == 0) w_eff = 1;
		else if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
		active_w = w_eff;
		active_h = (height_data == '0) ? 1 : height_data;
		// a width shrink in mid frame keeps the old backlog
		if (w_eff + 1 > drain_depth) drain_depth = w_eff + 1;
		write_reg(REG_IMG_WIDTH, width_data);
		write_reg(REG_IMG_HEIGHT, height_data);
		write_reg(REG_FILTER_MODE, {15'($urandom), mode});
		cfg_valid <= 1'b0;
	endtask

	// Present one item, with random hold-off before it; tvalid stays high
	// on return so a following item does not toggle it within one step.
	task automatic send_item(input logic cmd, input logic [PIX_W-1:0] px);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= px;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		if (cmd == CMD_PIXEL) begin
			pixels_sent++;
			since_flush++;
		end else begin
			drains_sent++;
		end
	endtask

	// Hold the sender until every predicted pixel is out, then let the
	// pipeline run dry (items that produce nothing may still be in flight).
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Empty the pipeline; extra drains hit an empty pipeline and do nothing.
	task automatic flush(input int extra);
		int unsigned depth;
		depth = (since_flush < drain_depth) ? since_flush : drain_depth;
		repeat (depth + extra) send_item(CMD_DRAIN, 8'($urandom));
		drain_depth = active_w + 1;
		since_flush = 0;
	endtask

	// Mostly binary content: full_pct of 255, the rest mostly 0, some gray.
	function automatic logic [PIX_W-1:0] pick_pixel(input int full_pct);
		int r;
		r = $urandom_range(99);
		if (r < full_pct) return PIX_FULL;
		if (r < 92) return PIX_ZERO;
		return 8'($urandom);
	endfunction

	task automatic send_pixels(input int count, input int full_pct);
		repeat (count) begin
			// now and then stall the sender until the output side catches up
			if ($urandom_range(149) == 0) settle();
			send_item(CMD_PIXEL, pick_pixel(full_pct));
		end
	endtask

	logic [PIX_W-1:0] erode_frame  [9] = '{PIX_FULL, PIX_FULL, PIX_FULL,
	                                       PIX_FULL, 8'h01,    PIX_FULL,
	                                       PIX_FULL, PIX_FULL, 8'hFE};
	logic [PIX_W-1:0] dilate_frame [9] = '{PIX_ZERO, 8'hFE,    PIX_ZERO,
	                                       PIX_ZERO, 8'h80,    PIX_ZERO,
	                                       PIX_ZERO, PIX_ZERO, PIX_FULL};

	initial begin
		int n;
		int density;
		logic [CFG_DATA_W-1:0] w_data, h_data;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed: one drain into an empty pipeline, then two 3x3 frames
		send_item(CMD_DRAIN, PIX_FULL);
		settle();

		// erosion: gray center and corner are not zero, so the center goes full
		configure(16'd3, 16'd3, MODE_ERODE);
		foreach (erode_frame[i]) send_item(CMD_PIXEL, erode_frame[i]);
		flush(1);
		settle();

		// dilation: only the exact 255 in the corner may set the center
		configure(16'd3, 16'd3, MODE_DILATE);
		foreach (dilate_frame[i]) send_item(CMD_PIXEL, dilate_frame[i]);
		flush(0);
		settle();

		// --- corner sizes
		// width 0 and height 0 act as 1x1: every pixel is a frame end
		configure(16'd0, 16'd0, MODE_ERODE);
		send_pixels(5, 50);
		flush(1);
		settle();

		// tallest frame, abandoned after a few rows by draining
		configure(16'd7, 16'hFFFF, MODE_DILATE);
		send_pixels(40, 40);
		flush(1);
		settle();

		// mid-frame changes with the row stores already filled: shrink the
		// height below the current row, then narrow the width in mid row
		configure(16'd6, 16'd20, MODE_ERODE);
		send_pixels(51, 75);
		settle();
		configure(16'd6, 16'd4, MODE_DILATE);
		send_pixels(30, 30);
		settle();
		configure(16'd4, 16'd4, MODE_DILATE);
		send_pixels(20, 30);
		flush(2);
		settle();

		// --- random sequences
		while (random_items < RANDOM_ITEMS) begin
			settle();
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 58;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 58;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			case ($urandom_range(19))
				0:       w_data = 16'd0;
				1, 2:    w_data = 16'($urandom_range(11, 24));
				default: w_data = 16'($urandom_range(1, 10));
			endcase
			h_data = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(1, 7));
			configure(w_data, h_data, 1'($urandom));

			if ($urandom_range(9) < 7) begin
				// well-formed: one to three back-to-back frames, then drain
				n = $urandom_range(1, 3) * active_w * active_h;
				density = $urandom_range(30, 95);
				send_pixels(n, density);
			end else begin
				// noise: arbitrary pixels with drains sprinkled in mid frame
				n = $urandom_range(1, 2 * active_w * active_h + 4);
				repeat (n)
					send_item(($urandom_range(99) < 15) ? CMD_DRAIN : CMD_PIXEL,
						8'($urandom));
			end
			flush($urandom_range(0, 2));
			random_items += n;
		end

		// --- out-of-range width acts as the widest row: the first results
		// appear only once a full row plus two pixels are in; no drain follows
		settle();
		configure(16'hFFFF, 16'd2, MODE_ERODE);
		send_pixels(MAX_WIDTH + 3, 60);

		// --- wind down: all results out, then a quiet tail for strays
		settle();
		repeat (20) @(negedge clk);

		$display("Sent %0d pixel items and %0d drain items with %0d register writes;",
			pixels_sent, drains_sent, reg_writes);
		$display("checked %0d output items across %0d frame ends in both filter modes.",
			results_seen, frames_seen);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
